/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge, off while reset is held.
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cis_pkg.sv */
// ----------------------------------------------------------------------------
// Counting integer set package
// Request and response words, request codes and sequencer states.
// ----------------------------------------------------------------------------
package cis_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_ERASE  = 2'd1;
    localparam logic [1:0] REQ_COUNT  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  low_value;
        logic [10:0] high_value;
    } req_t;

    typedef struct packed {
        logic [10:0] range_count;
        logic [10:0] total_members;
        logic        out_of_range;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF,
        ST_UP_RD,
        ST_UP_WR,
        ST_CNT_TEST,
        ST_CNT_LACC,
        ST_CNT_RACC,
        ST_FINISH
    } state_t;

endpackage

/* hw/rtl/cis_stream_if.sv */
// ----------------------------------------------------------------------------
// Counting integer set stream channel
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
interface cis_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/counting_integer_set_core.sv */
// An insert or erase that changes the set walks from leaf to root, with one read and one
// write of the count memory per node, the leaf being read twice; a range count reads up to two nodes per level.
// One request is handled at a time; req.ready is high only in idle, and the response
// register frees it while a word waits.
// Reset: asynchronous, active low; afterwards a clearing pass writes zero to all 2*UNIVERSE
// words of the count memory before the first request is taken.
// ----------------------------------------------------------------------------
// Counting integer set core
// Binary count tree over 0..UNIVERSE-1 with insert, erase and range count,
// walked one node per memory access by a small sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module counting_integer_set_core #(
    parameter int UNIVERSE = 1024,
    parameter int LEVELS   = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    cis_stream_if.sink           req,
    cis_stream_if.source         rsp
);
    import cis_pkg::*;

    localparam int CW    = LEVELS + 1;
    localparam int AW    = LEVELS + 1;
    localparam int PW    = LEVELS + 2;
    localparam int DEPTH = 2 * UNIVERSE;

    logic [CW-1:0] mem [DEPTH];
    logic [CW-1:0] rd_data_reg;

    state_t        state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [PW-1:0] l_reg, l_next;
    logic [PW-1:0] r_reg, r_next;
    logic [CW-1:0] sum_reg, sum_next;
    logic [CW-1:0] mc_reg, mc_next;
    logic          dec_reg, dec_next;
    logic          oor_reg, oor_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_data_reg, rsp_data_next;

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [CW-1:0] mem_wdata;

    logic [31:0]   lo32;
    logic [31:0]   hi32;
    logic [31:0]   hic32;
    logic [PW-1:0] r_dec;
    logic          present;

    assign lo32    = 32'(req.data.low_value);
    assign hi32    = 32'(req.data.high_value);
    assign hic32   = (hi32 > 32'(UNIVERSE)) ? 32'(UNIVERSE) : hi32;
    assign r_dec   = r_reg - PW'(1);
    assign present = (rd_data_reg != '0);

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= REQ_INSERT;
            clr_reg       <= '0;
            idx_reg       <= '0;
            l_reg         <= '0;
            r_reg         <= '0;
            sum_reg       <= '0;
            mc_reg        <= '0;
            dec_reg       <= 1'b0;
            oor_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            clr_reg       <= clr_next;
            idx_reg       <= idx_next;
            l_reg         <= l_next;
            r_reg         <= r_next;
            sum_reg       <= sum_next;
            mc_reg        <= mc_next;
            dec_reg       <= dec_next;
            oor_reg       <= oor_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        sum_next       = sum_reg;
        mc_next        = mc_reg;
        dec_next       = dec_reg;
        oor_next       = oor_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = idx_reg;
        mem_wdata      = '0;
        req.ready      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next  = req.data.req_type;
                    sum_next = '0;
                    oor_next = 1'b0;
                    case (req.data.req_type)
                        REQ_INSERT, REQ_ERASE:
                        begin
                            if (lo32 >= 32'(UNIVERSE))
                            begin
                                oor_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_addr   = AW'(32'(UNIVERSE) + lo32);
                                idx_next   = AW'(32'(UNIVERSE) + lo32);
                                state_next = ST_LEAF;
                            end
                        end
                        REQ_COUNT:
                        begin
                            if (lo32 >= hic32)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                l_next     = PW'(32'(UNIVERSE) + lo32);
                                r_next     = PW'(32'(UNIVERSE) + hic32);
                                state_next = ST_CNT_TEST;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_LEAF:
            begin
                if ((op_reg == REQ_INSERT && !present) || (op_reg == REQ_ERASE && present))
                begin
                    dec_next   = (op_reg == REQ_ERASE);
                    mem_re     = 1'b1;
                    mem_addr   = idx_reg;
                    state_next = ST_UP_WR;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_UP_RD:
            begin
                mem_re     = 1'b1;
                mem_addr   = idx_reg;
                state_next = ST_UP_WR;
            end
            ST_UP_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = idx_reg;
                mem_wdata = dec_reg ? (rd_data_reg - CW'(1)) : (rd_data_reg + CW'(1));
                if (idx_reg == AW'(1))
                begin
                    mc_next    = dec_reg ? (mc_reg - CW'(1)) : (mc_reg + CW'(1));
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg >> 1;
                    state_next = ST_UP_RD;
                end
            end
            ST_CNT_TEST:
            begin
                if (l_reg >= r_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (l_reg[0])
                begin
                    mem_re     = 1'b1;
                    mem_addr   = l_reg[AW-1:0];
                    l_next     = l_reg + PW'(1);
                    state_next = ST_CNT_LACC;
                end
                else if (r_reg[0])
                begin
                    mem_re     = 1'b1;
                    mem_addr   = r_dec[AW-1:0];
                    r_next     = r_dec;
                    state_next = ST_CNT_RACC;
                end
                else
                begin
                    l_next = l_reg >> 1;
                    r_next = r_reg >> 1;
                end
            end
            ST_CNT_LACC:
            begin
                sum_next = sum_reg + rd_data_reg;
                if (r_reg[0])
                begin
                    mem_re     = 1'b1;
                    mem_addr   = r_dec[AW-1:0];
                    r_next     = r_dec;
                    state_next = ST_CNT_RACC;
                end
                else
                begin
                    l_next     = l_reg >> 1;
                    r_next     = r_reg >> 1;
                    state_next = ST_CNT_TEST;
                end
            end
            ST_CNT_RACC:
            begin
                sum_next   = sum_reg + rd_data_reg;
                l_next     = l_reg >> 1;
                r_next     = r_reg >> 1;
                state_next = ST_CNT_TEST;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.range_count   = 11'(32'(sum_reg));
                    rsp_data_next.total_members = 11'(32'(mc_reg));
                    rsp_data_next.out_of_range  = oor_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_RST(a_accept_leaves_idle, clk, rst_n, (req.valid && req.ready) |=> (state_reg != ST_IDLE), "accepted word did not start the sequencer")
    `ASSERT_RST(a_members_bounded, clk, rst_n, mc_reg <= CW'(UNIVERSE), "member count exceeds universe")
    `ASSERT_ALWAYS(a_no_rsp_in_clear, clk, (state_reg == ST_CLEAR) |-> !rsp.valid, "response during clearing pass")
    `ASSERT_RST(a_oor_no_count, clk, rst_n, (rsp.valid && rsp.data.out_of_range) |-> (rsp.data.range_count == 11'd0), "out of range word carries a count")

endmodule
